/* rtl/mpd2_pkg.sv */
// Shared constants, types and helpers for the 2x2 max-pooling downsampler.
`timescale 1ns / 1ps

package mpd2_pkg;

   localparam int PIXEL_BITS = 16;
   localparam int MAX_COLS   = 4096;
   localparam int MAX_ROWS   = 4096;
   localparam int DIM_BITS   = 13;
   localparam int COL_BITS   = 12;
   localparam int ROW_BITS   = 12;
   localparam int LINE_DEPTH = MAX_COLS / 2;
   localparam int LINE_ADDR_BITS = $clog2(LINE_DEPTH);
   localparam int COORD_BITS = 11;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [DIM_BITS-1:0] MAX_COLS_DIM = DIM_BITS'(MAX_COLS);
   localparam logic [DIM_BITS-1:0] MAX_ROWS_DIM = DIM_BITS'(MAX_ROWS);
   localparam logic [COL_BITS-1:0] WIDTH_RESET_LAST  = COL_BITS'(640 - 1);
   localparam logic [ROW_BITS-1:0] HEIGHT_RESET_LAST = ROW_BITS'(480 - 1);

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      pixel_type              partial;
      logic                   use_line;
      logic                   use_partial;
      logic [COORD_BITS-1:0]  out_row;
      logic [COORD_BITS-1:0]  out_col;
      logic                   last;
   } pend_type;

   // Turns a written dimension into the index of its last row or column.
   function automatic logic [COL_BITS-1:0] last_index(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] maxv);
      logic [DIM_BITS-1:0] lim;
      lim = v;
      if (v == '0) begin
         lim = DIM_BITS'(1);
      end else if (v > maxv) begin
         lim = maxv;
      end
      return COL_BITS'(lim - DIM_BITS'(1));
   endfunction

   function automatic pixel_type pix_max(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

/* rtl/max_pool_downsample_2x2.sv */
// Top level of the 2x2 stride-2 max-pooling downsampler.
// A result moves through the pending register and then the output register.
// Throughput: one pixel per cycle when not stalled; line RAM has one read and write port pair.
// Reset clears the counters and the pipeline and sets the image to 640 by 480.
// The line RAM is not cleared; every entry is written in a top row before its read data is used.
`timescale 1ns / 1ps

module max_pool_downsample_2x2 (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [15:0]                            req_pixel_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [15:0]                            rsp_pooled_value,
   output logic [10:0]                            rsp_out_row,
   output logic [10:0]                            rsp_out_col,
   output logic                                   rsp_last_of_image,
   input  logic                                   csr_write_en,
   input  logic [mpd2_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mpd2_pkg::DIM_BITS-1:0]          csr_write_data
);

   logic [mpd2_pkg::COL_BITS-1:0] width_last_ff, width_last_in;
   logic [mpd2_pkg::ROW_BITS-1:0] height_last_ff, height_last_in;
   logic [mpd2_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [mpd2_pkg::ROW_BITS-1:0] row_ff, row_in;
   mpd2_pkg::pixel_type            left_ff, left_in;
   logic                           pend_valid_ff, pend_valid_in;
   mpd2_pkg::pend_type             pend_ff, pend_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   mpd2_pkg::pixel_type            rsp_value_ff, rsp_value_in;
   logic [10:0]                    rsp_row_ff, rsp_row_in;
   logic [10:0]                    rsp_col_ff, rsp_col_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           accept;
   logic                           out_free;
   logic                           last_col;
   logic                           last_row;
   logic                           col_odd;
   logic                           top_pair;
   logic                           emit;
   mpd2_pkg::pixel_type            pixel;
   mpd2_pkg::pixel_type            pair_value;
   mpd2_pkg::pixel_type            partial;
   mpd2_pkg::pixel_type            line_data;
   mpd2_pkg::pixel_type            final_value;
   logic                           line_wr_en;
   logic [mpd2_pkg::LINE_ADDR_BITS-1:0] line_addr;

   assign pixel      = req_pixel_value;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !pend_valid_ff || out_free;
   assign accept     = req_valid && req_ready;

   assign last_col   = (col_ff == width_last_ff);
   assign last_row   = (row_ff == height_last_ff);
   assign col_odd    = col_ff[0];
   assign top_pair   = !row_ff[0] && !last_row;
   assign pair_value = mpd2_pkg::pix_max(left_ff, pixel);
   assign partial    = col_odd ? pair_value : pixel;
   assign emit       = !top_pair && (col_odd || last_col);
   assign line_addr  = col_ff[mpd2_pkg::COL_BITS-1:1];
   assign line_wr_en = accept && top_pair && (col_odd || last_col);

   mpd2_line_ram #(
      .DEPTH (mpd2_pkg::LINE_DEPTH),
      .WIDTH (mpd2_pkg::PIXEL_BITS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_addr),
      .wr_data (partial),
      .rd_en   (accept),
      .rd_addr (line_addr),
      .rd_data (line_data)
   );

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      left_in        = left_ff;
      if (csr_write_en) begin
         case (csr_index)
            mpd2_pkg::CSR_IMAGE_WIDTH: begin
               width_last_in = mpd2_pkg::last_index(csr_write_data, mpd2_pkg::MAX_COLS_DIM);
            end
            mpd2_pkg::CSR_IMAGE_HEIGHT: begin
               height_last_in = mpd2_pkg::last_index(csr_write_data, mpd2_pkg::MAX_ROWS_DIM);
            end
            default: begin
            end
         endcase
         col_in  = '0;
         row_in  = '0;
         left_in = '0;
      end else if (accept) begin
         if (!col_odd && !last_col) begin
            left_in = pixel;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + mpd2_pkg::ROW_BITS'(1);
         end else begin
            col_in = col_ff + mpd2_pkg::COL_BITS'(1);
         end
      end
   end

   always_comb begin
      pend_in.partial     = partial;
      pend_in.use_line    = row_ff[0];
      pend_in.use_partial = !(row_ff[0] && !col_odd);
      pend_in.out_row     = row_ff[mpd2_pkg::ROW_BITS-1:1];
      pend_in.out_col     = col_ff[mpd2_pkg::COL_BITS-1:1];
      pend_in.last        = last_row && last_col;
      pend_valid_in       = pend_valid_ff;
      if (accept) begin
         pend_valid_in = emit;
      end else if (out_free) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (pend_ff.use_line && pend_ff.use_partial) begin
         final_value = mpd2_pkg::pix_max(line_data, pend_ff.partial);
      end else if (pend_ff.use_line) begin
         final_value = line_data;
      end else begin
         final_value = pend_ff.partial;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = pend_valid_ff;
         rsp_value_in = final_value;
         rsp_row_in   = pend_ff.out_row;
         rsp_col_in   = pend_ff.out_col;
         rsp_last_in  = pend_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= mpd2_pkg::WIDTH_RESET_LAST;
         height_last_ff <= mpd2_pkg::HEIGHT_RESET_LAST;
         col_ff         <= '0;
         row_ff         <= '0;
         left_ff        <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         left_ff        <= left_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pooled_value  = rsp_value_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_last_of_image = rsp_last_ff;

endmodule

/* rtl/mpd2_line_ram.sv */
// Simple dual-port line buffer RAM with a registered read port.
`timescale 1ns / 1ps

module mpd2_line_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the 2x2 max-pooling downsampler with a scoreboard class.
`timescale 1ns / 1ps

module testbench;

   typedef logic [mpd2_pkg::DIM_BITS-1:0] dim_type;

   typedef struct packed {
      mpd2_pkg::pixel_type             value;
      logic [mpd2_pkg::COORD_BITS-1:0] row;
      logic [mpd2_pkg::COORD_BITS-1:0] col;
      logic                            last;
   } pooled_pixel_type;

   class pool_scoreboard;
      dim_type                       width_reg;
      dim_type                       height_reg;
      mpd2_pkg::pixel_type           pair_max [0:mpd2_pkg::LINE_DEPTH-1];
      mpd2_pkg::pixel_type           left_hold;
      logic [mpd2_pkg::ROW_BITS-1:0] row_cnt;
      logic [mpd2_pkg::COL_BITS-1:0] col_cnt;
      pooled_pixel_type              pooled_q [$];
      int unsigned                   errors;
      int unsigned                   results;

      function new();
         width_reg  = dim_type'(640);
         height_reg = dim_type'(480);
         left_hold  = '0;
         row_cnt    = '0;
         col_cnt    = '0;
         errors     = 0;
         results    = 0;
         for (int i = 0; i < mpd2_pkg::LINE_DEPTH; i++) begin
            pair_max[i] = '0;
         end
      endfunction

      function int unsigned clamp_dim(input dim_type v, input int unsigned limit);
         if (v == '0) return 1;
         if (v > limit) return limit;
         return v;
      endfunction

      function mpd2_pkg::pixel_type larger_of(input mpd2_pkg::pixel_type a,
                                              input mpd2_pkg::pixel_type b);
         return (a > b) ? a : b;
      endfunction

      function void set_register(input logic [mpd2_pkg::CSR_INDEX_BITS-1:0] index,
                                 input dim_type data);
         if (index == mpd2_pkg::CSR_IMAGE_WIDTH) begin
            width_reg = data;
         end else begin
            height_reg = data;
         end
         left_hold = '0;
         row_cnt   = '0;
         col_cnt   = '0;
      endfunction

      function void note_pixel(input mpd2_pkg::pixel_type pix);
         int unsigned                         w;
         int unsigned                         h;
         logic [mpd2_pkg::ROW_BITS-1:0]       row;
         logic [mpd2_pkg::COL_BITS-1:0]       col;
         logic [mpd2_pkg::LINE_ADDR_BITS-1:0] idx;
         bit                                  last_col;
         bit                                  last_row;
         bit                                  emit;
         mpd2_pkg::pixel_type                 value;
         pooled_pixel_type                    item;
         w        = clamp_dim(width_reg, mpd2_pkg::MAX_COLS);
         h        = clamp_dim(height_reg, mpd2_pkg::MAX_ROWS);
         row      = row_cnt;
         col      = col_cnt;
         idx      = col[mpd2_pkg::COL_BITS-1:1];
         last_col = (32'(col) + 1 >= w);
         last_row = (32'(row) + 1 >= h);
         emit     = 1'b0;
         value    = '0;
         if (!row[0] && !last_row) begin
            if (col[0]) begin
               pair_max[idx] = larger_of(left_hold, pix);
            end else if (last_col) begin
               pair_max[idx] = pix;
            end else begin
               left_hold = pix;
            end
         end else if (!row[0]) begin
            if (col[0]) begin
               value = larger_of(left_hold, pix);
               emit  = 1'b1;
            end else if (last_col) begin
               value = pix;
               emit  = 1'b1;
            end else begin
               left_hold = pix;
            end
         end else begin
            if (col[0]) begin
               value = larger_of(pair_max[idx], larger_of(left_hold, pix));
               emit  = 1'b1;
            end else if (last_col) begin
               value = pair_max[idx];
               emit  = 1'b1;
            end else begin
               left_hold = pix;
            end
         end
         if (emit) begin
            item.value = value;
            item.row   = row[mpd2_pkg::ROW_BITS-1:1];
            item.col   = col[mpd2_pkg::COL_BITS-1:1];
            item.last  = last_row && last_col;
            pooled_q.insert(pooled_q.size(), item);
         end
         if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? '0 : row + 1'b1;
         end else begin
            col_cnt = col + 1'b1;
         end
      endfunction

      function void compare(input string name, input int unsigned want, input int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(input mpd2_pkg::pixel_type value,
                                 input logic [mpd2_pkg::COORD_BITS-1:0] row,
                                 input logic [mpd2_pkg::COORD_BITS-1:0] col, input logic last);
         pooled_pixel_type want;
         results++;
         if (pooled_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual value %0h row %0d col %0d",
                     $time, value, row, col);
            return;
         end
         want = pooled_q.pop_front();
         compare("pooled_value", want.value, value);
         compare("out_row", want.row, row);
         compare("out_col", want.col, col);
         compare("last_of_image", want.last, last);
      endfunction

      function int unsigned pending();
         return pooled_q.size();
      endfunction

      function void report_leftover();
         if (pooled_q.size() != 0) begin
            errors += pooled_q.size();
            $display("%0t: %0d expected pooled results never arrived", $time, pooled_q.size());
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [15:0]                         req_pixel_value;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [15:0]                         rsp_pooled_value;
   logic [10:0]                         rsp_out_row;
   logic [10:0]                         rsp_out_col;
   logic                                rsp_last_of_image;
   logic                                csr_write_en;
   logic [mpd2_pkg::CSR_INDEX_BITS-1:0] csr_index;
   dim_type                             csr_write_data;

   pool_scoreboard sb;
   bit             steady_phase;
   bit             hold_off;
   int unsigned    pixels_sent;
   int unsigned    writes_done;

   max_pool_downsample_2x2 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pooled_value  (rsp_pooled_value),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_of_image (rsp_last_of_image),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL max_pool_downsample_2x2");
      $finish;
   end

   function automatic mpd2_pkg::pixel_type rand_pixel();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return mpd2_pkg::pixel_type'($urandom());
      endcase
   endfunction

   function automatic int unsigned pick_dim(input int unsigned top);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return 0;
      if (roll < 75) return $urandom_range(1, 6);
      return $urandom_range(7, top);
   endfunction

   task automatic send_pixel(input mpd2_pkg::pixel_type pix);
      if (!steady_phase && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < 31);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(pix);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic send_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_pixel(rand_pixel());
      end
   endtask

   task automatic drain();
      int unsigned guard;
      guard = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && guard < 400000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [mpd2_pkg::CSR_INDEX_BITS-1:0] index,
                            input dim_type data);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      sb.set_register(index, data);
      writes_done++;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // The receiver idles at random and, on request, holds off for a long stretch.
   initial begin
      int held;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_ready <= 1'b0;
            for (held = 0; held < 300; held++) begin
               @(negedge clock);
            end
         end else begin
            rsp_ready <= steady_phase || ($urandom_range(0, 99) >= 31);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_pooled_value, rsp_out_row, rsp_out_col, rsp_last_of_image);
      end
   end

   initial begin
      int unsigned frame_size;
      int unsigned count;
      int unsigned random_sent;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_value = '0;
      csr_write_en    = 1'b0;
      csr_index       = mpd2_pkg::CSR_IMAGE_WIDTH;
      csr_write_data  = '0;
      steady_phase    = 1'b0;
      hold_off        = 1'b0;
      pixels_sent     = 0;
      writes_done     = 0;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Part of the top row at the reset size of 640 by 480 gives no results.
      send_random(64);
      drain();

      // Odd width and odd height together.
      write_reg(mpd2_pkg::CSR_IMAGE_WIDTH, dim_type'(3));
      write_reg(mpd2_pkg::CSR_IMAGE_HEIGHT, dim_type'(3));
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      send_pixel(16'h1234);
      send_pixel(16'h8000);
      send_pixel(16'h0001);
      send_pixel(16'h7FFF);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      send_pixel(16'hA5A5);
      drain();

      // Zero sizes act as a one by one frame.
      write_reg(mpd2_pkg::CSR_IMAGE_WIDTH, '0);
      write_reg(mpd2_pkg::CSR_IMAGE_HEIGHT, '0);
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      drain();

      write_reg(mpd2_pkg::CSR_IMAGE_WIDTH, dim_type'(2));
      write_reg(mpd2_pkg::CSR_IMAGE_HEIGHT, dim_type'(2));
      send_pixel(16'h0000);
      send_pixel(16'h0000);
      send_pixel(16'h0000);
      send_pixel(16'hFFFF);
      drain();

      write_reg(mpd2_pkg::CSR_IMAGE_HEIGHT, dim_type'(1));
      write_reg(mpd2_pkg::CSR_IMAGE_WIDTH, dim_type'(3));
      send_pixel(16'h8001);
      send_pixel(16'h7FFE);
      send_pixel(16'hFFFF);
      drain();

      // Oversized width on a single row; the receiver holds off while pixels keep coming.
      write_reg(mpd2_pkg::CSR_IMAGE_WIDTH, dim_type'(8191));
      write_reg(mpd2_pkg::CSR_IMAGE_HEIGHT, dim_type'(1));
      hold_off = 1'b1;
      send_random(48);
      drain();

      steady_phase = 1'b1;
      write_reg(mpd2_pkg::CSR_IMAGE_WIDTH, dim_type'(1));
      write_reg(mpd2_pkg::CSR_IMAGE_HEIGHT, dim_type'(8191));
      send_random(96);
      drain();
      steady_phase = 1'b0;

      // Random frames.
      random_sent = 0;
      while (random_sent < 400) begin
         case (random_sent == 0 ? 9 : $urandom_range(0, 9))
            0: write_reg(mpd2_pkg::CSR_IMAGE_WIDTH, dim_type'(pick_dim(24)));
            1: write_reg(mpd2_pkg::CSR_IMAGE_HEIGHT, dim_type'(pick_dim(7)));
            2: ;
            default: begin
               write_reg(mpd2_pkg::CSR_IMAGE_WIDTH, dim_type'(pick_dim(24)));
               write_reg(mpd2_pkg::CSR_IMAGE_HEIGHT, dim_type'(pick_dim(7)));
            end
         endcase
         frame_size = sb.clamp_dim(sb.width_reg, mpd2_pkg::MAX_COLS) *
                      sb.clamp_dim(sb.height_reg, mpd2_pkg::MAX_ROWS);
         if ($urandom_range(0, 9) < 8) begin
            count = frame_size * $urandom_range(1, 2);
         end else begin
            count = $urandom_range(1, frame_size);
         end
         if (count > 400 - random_sent) begin
            count = 400 - random_sent;
         end
         send_random(count);
         random_sent += count;
         drain();
      end

      sb.report_leftover();
      $display("Run covered %0d pixel transfers, %0d pooled results and %0d register writes,",
               pixels_sent, sb.results, writes_done);
      $display("with odd edges, one by one frames, saturated sizes and a long output stall.");
      if (sb.errors == 0) begin
         $display("PASS max_pool_downsample_2x2");
      end else begin
         $display("FAIL max_pool_downsample_2x2");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/mpd2_pkg.sv
rtl/mpd2_line_ram.sv
rtl/max_pool_downsample_2x2.sv
sim/testbench.sv
